// ===== rtl/core/cst_pkg.sv =====
// package for the c subset tokenizer: token kinds, pending classes, tables
// no dependencies
package cst_pkg;

    localparam int PositionBitsDefault = 16;
    localparam int QueueDepth = 4;

    localparam logic [5:0] K_EOF     = 6'd0;
    localparam logic [5:0] K_INVALID = 6'd1;
    localparam logic [5:0] K_IDENT   = 6'd2;
    localparam logic [5:0] K_LIT     = 6'd3;
    localparam logic [5:0] K_INT     = 6'd4;
    localparam logic [5:0] K_VOID    = 6'd5;
    localparam logic [5:0] K_RETURN  = 6'd6;
    localparam logic [5:0] K_IF      = 6'd7;
    localparam logic [5:0] K_ELSE    = 6'd8;
    localparam logic [5:0] K_WHILE   = 6'd9;
    localparam logic [5:0] K_FOR     = 6'd10;
    localparam logic [5:0] K_DOT     = 6'd19;

    localparam logic [4:0] CL_NONE   = 5'd0;
    localparam logic [4:0] CL_WORD   = 5'd1;
    localparam logic [4:0] CL_NUM    = 5'd2;
    localparam logic [4:0] CL_MINUS  = 5'd3;
    localparam logic [4:0] CL_PLUS   = 5'd4;
    localparam logic [4:0] CL_LT     = 5'd5;
    localparam logic [4:0] CL_SHL    = 5'd6;
    localparam logic [4:0] CL_GT     = 5'd7;
    localparam logic [4:0] CL_SHR    = 5'd8;
    localparam logic [4:0] CL_AMP    = 5'd9;
    localparam logic [4:0] CL_BAR    = 5'd10;
    localparam logic [4:0] CL_DOT    = 5'd11;
    localparam logic [4:0] CL_DOTDOT = 5'd12;
    localparam logic [4:0] CL_STAR   = 5'd13;
    localparam logic [4:0] CL_SLASH  = 5'd14;
    localparam logic [4:0] CL_PCT    = 5'd15;
    localparam logic [4:0] CL_CARET  = 5'd16;
    localparam logic [4:0] CL_EQ     = 5'd17;
    localparam logic [4:0] CL_BANG   = 5'd18;

    // character classification done by the front end
    typedef enum logic [2:0] {
        C_END, C_NEWLINE, C_SPACE, C_ALPHA, C_DIGIT, C_PUNCT, C_SINGLE
    } t_chclass;

    typedef struct packed {
        logic [7:0]  ch;
        t_chclass    cls;
        logic [4:0]  start_cls;
        logic [5:0]  single;
    } t_citem;

    typedef struct packed {
        logic [5:0] kind;
        logic [4:0] next_cls;
        logic       grows;
    } t_grow;

    function automatic logic [4:0] start_class(input logic [7:0] c);
        logic [4:0] r;
        begin
            case (c)
                8'h2D: r = CL_MINUS;
                8'h2B: r = CL_PLUS;
                8'h3C: r = CL_LT;
                8'h3E: r = CL_GT;
                8'h26: r = CL_AMP;
                8'h7C: r = CL_BAR;
                8'h2E: r = CL_DOT;
                8'h2A: r = CL_STAR;
                8'h2F: r = CL_SLASH;
                8'h25: r = CL_PCT;
                8'h5E: r = CL_CARET;
                8'h3D: r = CL_EQ;
                8'h21: r = CL_BANG;
                default: r = CL_NONE;
            endcase
            return r;
        end
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] r;
        begin
            case (c)
                8'h28: r = 6'd11;
                8'h29: r = 6'd12;
                8'h7B: r = 6'd13;
                8'h7D: r = 6'd14;
                8'h5B: r = 6'd15;
                8'h5D: r = 6'd16;
                8'h3B: r = 6'd17;
                8'h2C: r = 6'd18;
                8'h3F: r = 6'd21;
                8'h3A: r = 6'd22;
                8'h7E: r = 6'd53;
                default: r = K_INVALID;
            endcase
            return r;
        end
    endfunction

    // kind of a pending punctuator given nothing follows it
    function automatic logic [5:0] alone_kind(input logic [4:0] cl);
        logic [5:0] r;
        begin
            case (cl)
                CL_MINUS:  r = 6'd24;
                CL_PLUS:   r = 6'd23;
                CL_LT:     r = 6'd43;
                CL_SHL:    r = 6'd54;
                CL_GT:     r = 6'd44;
                CL_SHR:    r = 6'd55;
                CL_AMP:    r = 6'd50;
                CL_BAR:    r = 6'd51;
                CL_STAR:   r = 6'd25;
                CL_SLASH:  r = 6'd26;
                CL_PCT:    r = 6'd27;
                CL_CARET:  r = 6'd52;
                CL_EQ:     r = 6'd30;
                CL_BANG:   r = 6'd49;
                default:   r = K_DOT;
            endcase
            return r;
        end
    endfunction

    // growth of a pending punctuator by one more character
    function automatic t_grow grow(input logic [4:0] cl, input logic [7:0] c);
        t_grow g;
        begin
            g = '{kind: 6'd0, next_cls: CL_NONE, grows: 1'b0};
            case (cl)
                CL_MINUS: begin
                    if (c == 8'h3E) g = '{6'd20, CL_NONE, 1'b1};
                    else if (c == 8'h3D) g = '{6'd35, CL_NONE, 1'b1};
                    else if (c == 8'h2D) g = '{6'd29, CL_NONE, 1'b1};
                end
                CL_PLUS: begin
                    if (c == 8'h3D) g = '{6'd34, CL_NONE, 1'b1};
                    else if (c == 8'h2B) g = '{6'd28, CL_NONE, 1'b1};
                end
                CL_LT: begin
                    if (c == 8'h3D) g = '{6'd45, CL_NONE, 1'b1};
                    else if (c == 8'h3C) g = '{6'd0, CL_SHL, 1'b1};
                end
                CL_SHL: if (c == 8'h3D) g = '{6'd36, CL_NONE, 1'b1};
                CL_GT: begin
                    if (c == 8'h3D) g = '{6'd46, CL_NONE, 1'b1};
                    else if (c == 8'h3E) g = '{6'd0, CL_SHR, 1'b1};
                end
                CL_SHR: if (c == 8'h3D) g = '{6'd37, CL_NONE, 1'b1};
                CL_AMP: begin
                    if (c == 8'h3D) g = '{6'd38, CL_NONE, 1'b1};
                    else if (c == 8'h26) g = '{6'd47, CL_NONE, 1'b1};
                end
                CL_BAR: begin
                    if (c == 8'h3D) g = '{6'd40, CL_NONE, 1'b1};
                    else if (c == 8'h7C) g = '{6'd48, CL_NONE, 1'b1};
                end
                CL_DOT:    if (c == 8'h2E) g = '{6'd0, CL_DOTDOT, 1'b1};
                CL_DOTDOT: if (c == 8'h2E) g = '{6'd56, CL_NONE, 1'b1};
                CL_STAR:   if (c == 8'h3D) g = '{6'd31, CL_NONE, 1'b1};
                CL_SLASH:  if (c == 8'h3D) g = '{6'd32, CL_NONE, 1'b1};
                CL_PCT:    if (c == 8'h3D) g = '{6'd33, CL_NONE, 1'b1};
                CL_CARET:  if (c == 8'h3D) g = '{6'd39, CL_NONE, 1'b1};
                CL_EQ:     if (c == 8'h3D) g = '{6'd41, CL_NONE, 1'b1};
                CL_BANG:   if (c == 8'h3D) g = '{6'd42, CL_NONE, 1'b1};
                default: g = '{6'd0, CL_NONE, 1'b0};
            endcase
            return g;
        end
    endfunction

    function automatic logic [5:0] word_kind(input logic [47:0] p, input logic [2:0] len);
        logic [5:0] r;
        begin
            r = K_IDENT;
            if (len == 3'd3 && p[23:0] == 24'h746E69) r = K_INT;
            if (len == 3'd4 && p[31:0] == 32'h64696F76) r = K_VOID;
            if (len == 3'd6 && p == 48'h6E7275746572) r = K_RETURN;
            if (len == 3'd2 && p[15:0] == 16'h6669) r = K_IF;
            if (len == 3'd4 && p[31:0] == 32'h65736C65) r = K_ELSE;
            if (len == 3'd5 && p[39:0] == 40'h656C696877) r = K_WHILE;
            if (len == 3'd3 && p[23:0] == 24'h726F66) r = K_FOR;
            return r;
        end
    endfunction

endpackage

// ===== rtl/core/cst_front.sv =====
// front end: accepts characters and classifies them into a short queue
// depends on cst_pkg
module cst_front #(
    parameter int Depth = cst_pkg::QueueDepth
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  logic [7:0]      i_ch,
    output logic            o_valid,
    output cst_pkg::t_citem o_item,
    input  logic            i_take
);
    localparam int Aw = $clog2(Depth);

    cst_pkg::t_citem  r_mem [Depth];
    logic [Aw-1:0]    r_wp, r_rp;
    logic [Aw:0]      r_cnt;
    cst_pkg::t_citem  w_item;
    logic             w_wr, w_rd;

    always_comb begin
        w_item.ch = i_ch;
        w_item.start_cls = cst_pkg::start_class(i_ch);
        w_item.single = cst_pkg::single_kind(i_ch);
        if (i_ch == 8'd0) w_item.cls = cst_pkg::C_END;
        else if (i_ch == 8'h0A) w_item.cls = cst_pkg::C_NEWLINE;
        else if (i_ch == 8'h20 || (i_ch >= 8'd9 && i_ch <= 8'd13)) w_item.cls = cst_pkg::C_SPACE;
        else if ((i_ch >= 8'h61 && i_ch <= 8'h7A) || (i_ch >= 8'h41 && i_ch <= 8'h5A)
                 || i_ch == 8'h5F) w_item.cls = cst_pkg::C_ALPHA;
        else if (i_ch >= 8'h30 && i_ch <= 8'h39) w_item.cls = cst_pkg::C_DIGIT;
        else if (w_item.start_cls != cst_pkg::CL_NONE) w_item.cls = cst_pkg::C_PUNCT;
        else w_item.cls = cst_pkg::C_SINGLE;
    end

    assign o_full  = (r_cnt == (Aw+1)'(Depth));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= w_item;
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= (r_wp == Aw'(Depth-1)) ? '0 : r_wp + 1'b1;
            if (w_rd) r_rp <= (r_rp == Aw'(Depth-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (Aw+1)'(w_wr) - (Aw+1)'(w_rd);
        end
    end
endmodule

// ===== rtl/core/cst_back.sv =====
// back end: lexer state, emits up to three tokens per character into a result queue
// depends on cst_pkg
module cst_back #(
    parameter int PositionBits = cst_pkg::PositionBitsDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  cst_pkg::t_citem i_item,
    output logic            o_take,
    output logic            o_empty,
    input  logic            i_pop,
    output logic [5:0]      o_token_kind,
    output logic [15:0]     o_begin_row,
    output logic [15:0]     o_begin_col,
    output logic [15:0]     o_finish_row,
    output logic [15:0]     o_finish_col,
    output logic            o_last_of_run
);
    localparam int Pb = PositionBits;
    localparam logic [Pb-1:0] PosMax = '1;
    localparam int Qd = 8;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] br, bc, fr, fc;
        logic        last;
    } t_tok;

    function automatic logic [Pb-1:0] sat_inc(input logic [Pb-1:0] v);
        return (v == PosMax) ? v : v + 1'b1;
    endfunction

    function automatic t_tok mk(input logic [5:0] k, input logic [Pb-1:0] br,
                                input logic [Pb-1:0] bc, input logic [Pb-1:0] fr,
                                input logic [Pb-1:0] fc);
        t_tok t;
        begin
            t.kind = k;
            t.br = 16'(br);
            t.bc = 16'(bc);
            t.fr = 16'(fr);
            t.fc = 16'(fc);
            t.last = 1'b0;
            return t;
        end
    endfunction

    logic [4:0]    r_cls, n_cls;
    logic [47:0]   r_pref, n_pref;
    logic [2:0]    r_len, n_len;
    logic [Pb-1:0] r_prow, n_prow, r_pcol, n_pcol, r_crow, n_crow, r_ccol, n_ccol;

    t_tok          w_tok [3];
    logic [1:0]    w_n;
    logic          w_used;
    cst_pkg::t_grow w_g;
    logic [Pb-1:0] w_mid;
    logic [7:0]    c;

    // result queue, eight entries, up to three written a cycle
    t_tok          r_q [Qd];
    logic [2:0]    r_wp, r_rp;
    logic [3:0]    r_cnt;
    logic          w_pop;

    assign c = i_item.ch;
    assign o_take = i_valid && (r_cnt <= 4'd5);
    assign o_empty = (r_cnt == 4'd0);
    assign w_pop = i_pop && !o_empty;
    assign {o_token_kind, o_begin_row, o_begin_col, o_finish_row, o_finish_col,
            o_last_of_run} = r_q[r_rp];

    always_comb begin
        n_cls = r_cls; n_pref = r_pref; n_len = r_len;
        n_prow = r_prow; n_pcol = r_pcol; n_crow = r_crow; n_ccol = r_ccol;
        w_n = 2'd0;
        w_used = 1'b0;
        w_tok[0] = '0; w_tok[1] = '0; w_tok[2] = '0;
        w_g = cst_pkg::grow(r_cls, c);
        w_mid = sat_inc(r_pcol);
        if (r_cls == cst_pkg::CL_WORD) begin
            if (i_item.cls == cst_pkg::C_ALPHA || i_item.cls == cst_pkg::C_DIGIT) begin
                if (r_len < 3'd6) n_pref = r_pref | (48'(c) << {r_len, 3'b000});
                if (r_len < 3'd7) n_len = r_len + 1'b1;
                n_ccol = sat_inc(r_ccol);
                w_used = 1'b1;
            end else begin
                w_tok[0] = mk(cst_pkg::word_kind(r_pref, r_len), r_prow, r_pcol, r_crow, r_ccol);
                w_n = 2'd1;
                n_cls = cst_pkg::CL_NONE;
            end
        end else if (r_cls == cst_pkg::CL_NUM) begin
            if (i_item.cls == cst_pkg::C_DIGIT) begin
                n_ccol = sat_inc(r_ccol);
                w_used = 1'b1;
            end else begin
                w_tok[0] = mk(cst_pkg::K_LIT, r_prow, r_pcol, r_crow, r_ccol);
                w_n = 2'd1;
                n_cls = cst_pkg::CL_NONE;
            end
        end else if (r_cls != cst_pkg::CL_NONE) begin
            if (w_g.grows) begin
                w_used = 1'b1;
                n_ccol = sat_inc(r_ccol);
                n_cls = w_g.next_cls;
                if (w_g.next_cls == cst_pkg::CL_NONE) begin
                    w_tok[0] = mk(w_g.kind, r_prow, r_pcol, r_crow, sat_inc(r_ccol));
                    w_n = 2'd1;
                end
            end else begin
                n_cls = cst_pkg::CL_NONE;
                if (r_cls == cst_pkg::CL_DOTDOT) begin
                    w_tok[0] = mk(cst_pkg::K_DOT, r_prow, r_pcol, r_crow, w_mid);
                    w_tok[1] = mk(cst_pkg::K_DOT, r_prow, w_mid, r_crow, r_ccol);
                    w_n = 2'd2;
                end else begin
                    w_tok[0] = mk(cst_pkg::alone_kind(r_cls), r_prow, r_pcol, r_crow, r_ccol);
                    w_n = 2'd1;
                end
            end
        end
        if (!w_used) begin
            case (i_item.cls)
                cst_pkg::C_END: begin
                    w_tok[w_n] = mk(cst_pkg::K_EOF, r_crow, r_ccol, r_crow, r_ccol);
                    w_n = w_n + 1'b1;
                    n_cls = cst_pkg::CL_NONE; n_pref = '0; n_len = '0;
                    n_prow = '0; n_pcol = '0; n_crow = '0; n_ccol = '0;
                end
                cst_pkg::C_NEWLINE: begin
                    n_crow = sat_inc(r_crow);
                    n_ccol = '0;
                end
                cst_pkg::C_SPACE: n_ccol = sat_inc(r_ccol);
                default: begin
                    n_prow = r_crow;
                    n_pcol = r_ccol;
                    n_ccol = sat_inc(r_ccol);
                    if (i_item.cls == cst_pkg::C_ALPHA) begin
                        n_cls = cst_pkg::CL_WORD;
                        n_pref = 48'(c);
                        n_len = 3'd1;
                    end else if (i_item.cls == cst_pkg::C_DIGIT) begin
                        n_cls = cst_pkg::CL_NUM;
                    end else if (i_item.cls == cst_pkg::C_PUNCT) begin
                        n_cls = i_item.start_cls;
                    end else begin
                        w_tok[w_n] = mk(i_item.single, r_crow, r_ccol, r_crow, sat_inc(r_ccol));
                        w_n = w_n + 1'b1;
                    end
                end
            endcase
        end
        if (w_n != 2'd0) w_tok[w_n - 1'b1].last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            if (w_n > 2'd0) r_q[r_wp] <= w_tok[0];
            if (w_n > 2'd1) r_q[r_wp + 3'd1] <= w_tok[1];
            if (w_n > 2'd2) r_q[r_wp + 3'd2] <= w_tok[2];
        end
        if (!i_rst_n) begin
            r_cls <= cst_pkg::CL_NONE;
            r_pref <= '0; r_len <= '0;
            r_prow <= '0; r_pcol <= '0; r_crow <= '0; r_ccol <= '0;
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (o_take) begin
                r_cls <= n_cls; r_pref <= n_pref; r_len <= n_len;
                r_prow <= n_prow; r_pcol <= n_pcol; r_crow <= n_crow; r_ccol <= n_ccol;
                r_wp <= r_wp + 3'(w_n);
            end
            if (w_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (o_take ? 4'(w_n) : 4'd0) - 4'(w_pop);
        end
    end
endmodule

// ===== rtl/core/c_subset_tokenizer.sv =====
// c subset tokenizer top: front classifier queue feeding the lexer back end
// a token is written into the result queue when the back end takes the character that ends it
// throughput: one character per cycle; the back end takes a character when its
// eight-entry result queue has room for three tokens
// reset: synchronous active-low i_rst_n clears position, pending token and both queues
module c_subset_tokenizer #(
    parameter int POSITION_BITS = cst_pkg::PositionBitsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_ch,
    output logic        empty,
    input  logic        pop,
    output logic [5:0]  o_token_kind,
    output logic [15:0] o_begin_row,
    output logic [15:0] o_begin_col,
    output logic [15:0] o_finish_row,
    output logic [15:0] o_finish_col,
    output logic        o_last_of_run
);
    logic            w_valid, w_take;
    cst_pkg::t_citem w_item;

    cst_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full), .i_ch(i_ch),
        .o_valid(w_valid), .o_item(w_item), .i_take(w_take)
    );

    cst_back #(.PositionBits(POSITION_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_valid), .i_item(w_item),
        .o_take(w_take), .o_empty(empty), .i_pop(pop),
        .o_token_kind(o_token_kind), .o_begin_row(o_begin_row), .o_begin_col(o_begin_col),
        .o_finish_row(o_finish_row), .o_finish_col(o_finish_col),
        .o_last_of_run(o_last_of_run)
    );

`ifndef ASSERT_OFF
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> w_valid) else $error("back end took from empty queue");
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_token_kind <= 6'd56) else $error("token kind out of range");
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_token_kind == cst_pkg::K_EOF) |-> o_last_of_run)
        else $error("eof not last of run");
`endif
endmodule

// ===== bench/c_subset_tokenizer_chk.sv =====
// checker for the c subset tokenizer: watches the character and token queues,
// predicts every token from the accepted characters and compares; uses cst_pkg
`timescale 1ns / 100ps

module c_subset_tokenizer_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  i_ch,
    input  logic        empty,
    input  logic        pop,
    input  logic [5:0]  o_token_kind,
    input  logic [15:0] o_begin_row,
    input  logic [15:0] o_begin_col,
    input  logic [15:0] o_finish_row,
    input  logic [15:0] o_finish_col,
    input  logic        o_last_of_run,
    output int          o_fail_count,
    output int          o_waiting,
    output int          o_token_count
);

    typedef enum logic [5:0] {
        T_LPAREN = 6'd11, T_RPAREN = 6'd12, T_LBRACE = 6'd13, T_RBRACE = 6'd14,
        T_LBRACK = 6'd15, T_RBRACK = 6'd16, T_SEMI = 6'd17, T_COMMA = 6'd18,
        T_DOT = 6'd19, T_ARROW = 6'd20, T_QUEST = 6'd21, T_COLON = 6'd22,
        T_PLUS = 6'd23, T_MINUS = 6'd24, T_STAR = 6'd25, T_SLASH = 6'd26,
        T_PCT = 6'd27, T_INC = 6'd28, T_DEC = 6'd29, T_ASSIGN = 6'd30,
        T_MUL_EQ = 6'd31, T_DIV_EQ = 6'd32, T_MOD_EQ = 6'd33, T_ADD_EQ = 6'd34,
        T_SUB_EQ = 6'd35, T_SHL_EQ = 6'd36, T_SHR_EQ = 6'd37, T_AND_EQ = 6'd38,
        T_XOR_EQ = 6'd39, T_OR_EQ = 6'd40, T_EQ_EQ = 6'd41, T_NE = 6'd42,
        T_LT = 6'd43, T_GT = 6'd44, T_LE = 6'd45, T_GE = 6'd46,
        T_LAND = 6'd47, T_LOR = 6'd48, T_NOT = 6'd49, T_AMP = 6'd50,
        T_BAR = 6'd51, T_CARET = 6'd52, T_TILDE = 6'd53, T_SHL = 6'd54,
        T_SHR = 6'd55, T_ELLIPSIS = 6'd56
    } t_punct;

    typedef struct {
        logic [5:0]  kind;
        logic [15:0] br;
        logic [15:0] bc;
        logic [15:0] fr;
        logic [15:0] fc;
        logic        last;
    } t_token;

    typedef struct {
        bit         grows;
        bit         chain;
        logic [4:0] next_cls;
        logic [5:0] kind;
    } t_ext;

    t_token      token_q[$];
    logic [4:0]  pend_cls;
    logic [47:0] word_text;
    logic [2:0]  word_len;
    logic [15:0] pend_row, pend_col, cur_row, cur_col;

    function automatic logic [15:0] sat(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [5:0] classify_word(input logic [47:0] p,
                                                 input logic [2:0] len);
        string s;
        logic [5:0] k;
        s = "";
        k = cst_pkg::K_IDENT;
        for (int i = 0; i < len && i < 6; i++) s = {s, string'(p[8*i +: 8])};
        if (len <= 3'd6) begin
            case (s)
                "int":    k = cst_pkg::K_INT;
                "void":   k = cst_pkg::K_VOID;
                "return": k = cst_pkg::K_RETURN;
                "if":     k = cst_pkg::K_IF;
                "else":   k = cst_pkg::K_ELSE;
                "while":  k = cst_pkg::K_WHILE;
                "for":    k = cst_pkg::K_FOR;
                default:  k = cst_pkg::K_IDENT;
            endcase
        end
        return k;
    endfunction

    function automatic logic [4:0] opener(input logic [7:0] c);
        case (c)
            "-": return cst_pkg::CL_MINUS;
            "+": return cst_pkg::CL_PLUS;
            "<": return cst_pkg::CL_LT;
            ">": return cst_pkg::CL_GT;
            "&": return cst_pkg::CL_AMP;
            "|": return cst_pkg::CL_BAR;
            ".": return cst_pkg::CL_DOT;
            "*": return cst_pkg::CL_STAR;
            "/": return cst_pkg::CL_SLASH;
            "%": return cst_pkg::CL_PCT;
            "^": return cst_pkg::CL_CARET;
            "=": return cst_pkg::CL_EQ;
            "!": return cst_pkg::CL_BANG;
            default: return cst_pkg::CL_NONE;
        endcase
    endfunction

    function automatic logic [5:0] lone_char(input logic [7:0] c);
        case (c)
            "(": return T_LPAREN;
            ")": return T_RPAREN;
            "{": return T_LBRACE;
            "}": return T_RBRACE;
            "[": return T_LBRACK;
            "]": return T_RBRACK;
            ";": return T_SEMI;
            ",": return T_COMMA;
            "?": return T_QUEST;
            ":": return T_COLON;
            "~": return T_TILDE;
            default: return cst_pkg::K_INVALID;
        endcase
    endfunction

    function automatic logic [5:0] held_kind(input logic [4:0] cl);
        case (cl)
            cst_pkg::CL_MINUS: return T_MINUS;
            cst_pkg::CL_PLUS:  return T_PLUS;
            cst_pkg::CL_LT:    return T_LT;
            cst_pkg::CL_SHL:   return T_SHL;
            cst_pkg::CL_GT:    return T_GT;
            cst_pkg::CL_SHR:   return T_SHR;
            cst_pkg::CL_AMP:   return T_AMP;
            cst_pkg::CL_BAR:   return T_BAR;
            cst_pkg::CL_STAR:  return T_STAR;
            cst_pkg::CL_SLASH: return T_SLASH;
            cst_pkg::CL_PCT:   return T_PCT;
            cst_pkg::CL_CARET: return T_CARET;
            cst_pkg::CL_EQ:    return T_ASSIGN;
            cst_pkg::CL_BANG:  return T_NOT;
            default:           return T_DOT;
        endcase
    endfunction

    function automatic t_ext extend(input logic [4:0] cl, input logic [7:0] c);
        t_ext e;
        e = '{grows: 1'b1, chain: 1'b0, next_cls: cst_pkg::CL_NONE, kind: cst_pkg::K_EOF};
        case ({cl, c})
            {cst_pkg::CL_MINUS, ">"}:  e.kind = T_ARROW;
            {cst_pkg::CL_MINUS, "="}:  e.kind = T_SUB_EQ;
            {cst_pkg::CL_MINUS, "-"}:  e.kind = T_DEC;
            {cst_pkg::CL_PLUS, "="}:   e.kind = T_ADD_EQ;
            {cst_pkg::CL_PLUS, "+"}:   e.kind = T_INC;
            {cst_pkg::CL_LT, "="}:     e.kind = T_LE;
            {cst_pkg::CL_LT, "<"}: begin
                e.chain = 1'b1;
                e.next_cls = cst_pkg::CL_SHL;
            end
            {cst_pkg::CL_SHL, "="}:    e.kind = T_SHL_EQ;
            {cst_pkg::CL_GT, "="}:     e.kind = T_GE;
            {cst_pkg::CL_GT, ">"}: begin
                e.chain = 1'b1;
                e.next_cls = cst_pkg::CL_SHR;
            end
            {cst_pkg::CL_SHR, "="}:    e.kind = T_SHR_EQ;
            {cst_pkg::CL_AMP, "="}:    e.kind = T_AND_EQ;
            {cst_pkg::CL_AMP, "&"}:    e.kind = T_LAND;
            {cst_pkg::CL_BAR, "="}:    e.kind = T_OR_EQ;
            {cst_pkg::CL_BAR, "|"}:    e.kind = T_LOR;
            {cst_pkg::CL_DOT, "."}: begin
                e.chain = 1'b1;
                e.next_cls = cst_pkg::CL_DOTDOT;
            end
            {cst_pkg::CL_DOTDOT, "."}: e.kind = T_ELLIPSIS;
            {cst_pkg::CL_STAR, "="}:   e.kind = T_MUL_EQ;
            {cst_pkg::CL_SLASH, "="}:  e.kind = T_DIV_EQ;
            {cst_pkg::CL_PCT, "="}:    e.kind = T_MOD_EQ;
            {cst_pkg::CL_CARET, "="}:  e.kind = T_XOR_EQ;
            {cst_pkg::CL_EQ, "="}:     e.kind = T_EQ_EQ;
            {cst_pkg::CL_BANG, "="}:   e.kind = T_NE;
            default:                   e.grows = 1'b0;
        endcase
        return e;
    endfunction

    task automatic add_token(input logic [5:0] k, input logic [15:0] br, input logic [15:0] bc,
                             input logic [15:0] fr, input logic [15:0] fc, inout int n);
        t_token t;
        t = '{kind: k, br: br, bc: bc, fr: fr, fc: fc, last: 1'b0};
        token_q.push_back(t);
        n++;
    endtask

    task automatic clear_lexer();
        pend_cls = cst_pkg::CL_NONE;
        word_text = '0;
        word_len = '0;
        pend_row = '0;
        pend_col = '0;
        cur_row = '0;
        cur_col = '0;
    endtask

    // advance the lexer by one character and queue the tokens it ends
    task automatic scan_char(input logic [7:0] c);
        bit used;
        int n;
        t_ext e;
        logic [15:0] mid;
        used = 1'b0;
        n = 0;
        if (pend_cls == cst_pkg::CL_WORD) begin
            if (is_alpha(c) || is_digit(c)) begin
                if (word_len < 3'd6) word_text[8*word_len +: 8] = c;
                if (word_len < 3'd7) word_len++;
                cur_col = sat(cur_col);
                used = 1'b1;
            end else begin
                add_token(classify_word(word_text, word_len), pend_row, pend_col,
                          cur_row, cur_col, n);
                pend_cls = cst_pkg::CL_NONE;
            end
        end else if (pend_cls == cst_pkg::CL_NUM) begin
            if (is_digit(c)) begin
                cur_col = sat(cur_col);
                used = 1'b1;
            end else begin
                add_token(cst_pkg::K_LIT, pend_row, pend_col, cur_row, cur_col, n);
                pend_cls = cst_pkg::CL_NONE;
            end
        end else if (pend_cls >= cst_pkg::CL_MINUS && pend_cls <= cst_pkg::CL_BANG) begin
            e = extend(pend_cls, c);
            if (e.grows) begin
                used = 1'b1;
                cur_col = sat(cur_col);
                if (e.chain) begin
                    pend_cls = e.next_cls;
                end else begin
                    add_token(e.kind, pend_row, pend_col, cur_row, cur_col, n);
                    pend_cls = cst_pkg::CL_NONE;
                end
            end else begin
                if (pend_cls == cst_pkg::CL_DOTDOT) begin
                    // two separate dots, the second one column later
                    mid = sat(pend_col);
                    add_token(T_DOT, pend_row, pend_col, cur_row, mid, n);
                    add_token(T_DOT, pend_row, mid, cur_row, cur_col, n);
                end else begin
                    add_token(held_kind(pend_cls), pend_row, pend_col, cur_row, cur_col, n);
                end
                pend_cls = cst_pkg::CL_NONE;
            end
        end else begin
            pend_cls = cst_pkg::CL_NONE;
        end

        if (!used) begin
            if (c == 8'd0) begin
                add_token(cst_pkg::K_EOF, cur_row, cur_col, cur_row, cur_col, n);
                clear_lexer();
            end else if (c == "\n") begin
                cur_row = sat(cur_row);
                cur_col = '0;
            end else if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
                cur_col = sat(cur_col);
            end else begin
                pend_row = cur_row;
                pend_col = cur_col;
                cur_col = sat(cur_col);
                if (is_alpha(c)) begin
                    pend_cls = cst_pkg::CL_WORD;
                    word_text = {40'd0, c};
                    word_len = 3'd1;
                end else if (is_digit(c)) begin
                    pend_cls = cst_pkg::CL_NUM;
                end else if (opener(c) != cst_pkg::CL_NONE) begin
                    pend_cls = opener(c);
                end else begin
                    add_token(lone_char(c), pend_row, pend_col, cur_row, cur_col, n);
                end
            end
        end
        if (n > 0) token_q[token_q.size() - 1].last = 1'b1;
    endtask

    initial begin
        clear_lexer();
        o_fail_count = 0;
        o_token_count = 0;
        o_waiting = 0;
    end

    always @(posedge i_clk) begin
        t_token want;
        if (i_rst_n) begin
            if (pop && !empty) begin
                o_token_count <= o_token_count + 1;
                if (token_q.size() == 0) begin
                    $display("%0t: token with none predicted: got kind %0d (%0d,%0d)-(%0d,%0d)",
                             $time, o_token_kind, o_begin_row, o_begin_col,
                             o_finish_row, o_finish_col);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = token_q.pop_front();
                    if (o_token_kind !== want.kind || o_begin_row !== want.br
                            || o_begin_col !== want.bc || o_finish_row !== want.fr
                            || o_finish_col !== want.fc || o_last_of_run !== want.last) begin
                        $display("%0t: token mismatch: expected kind %0d (%0d,%0d)-(%0d,%0d) %s",
                                 $time, want.kind, want.br, want.bc, want.fr, want.fc,
                                 $sformatf("last %0d", want.last));
                        $display("%0t: token mismatch: actual kind %0d (%0d,%0d)-(%0d,%0d) %s",
                                 $time, o_token_kind, o_begin_row, o_begin_col,
                                 o_finish_row, o_finish_col,
                                 $sformatf("last %0d", o_last_of_run));
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (push && !full) scan_char(i_ch);
        end
        o_waiting <= token_q.size();
    end

endmodule

// ===== bench/c_subset_tokenizer_tb.sv =====
// testbench top for the c subset tokenizer: clock, reset, character stimulus
// and token draining; depends on c_subset_tokenizer_chk and the block's rtl
`timescale 1ns / 100ps

module c_subset_tokenizer_tb;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_ch;
    logic        empty;
    logic        pop;
    logic [5:0]  o_token_kind;
    logic [15:0] o_begin_row, o_begin_col, o_finish_row, o_finish_col;
    logic        o_last_of_run;
    int          fail_count, waiting, token_count;
    int          char_count;
    bit          no_idle;

    c_subset_tokenizer u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_ch(i_ch),
        .empty(empty), .pop(pop), .o_token_kind(o_token_kind),
        .o_begin_row(o_begin_row), .o_begin_col(o_begin_col),
        .o_finish_row(o_finish_row), .o_finish_col(o_finish_col),
        .o_last_of_run(o_last_of_run)
    );

    c_subset_tokenizer_chk u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_ch(i_ch),
        .empty(empty), .pop(pop), .o_token_kind(o_token_kind),
        .o_begin_row(o_begin_row), .o_begin_col(o_begin_col),
        .o_finish_row(o_finish_row), .o_finish_col(o_finish_col),
        .o_last_of_run(o_last_of_run), .o_fail_count(fail_count),
        .o_waiting(waiting), .o_token_count(token_count)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #30_000_000;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

    // token drain with random stalls
    initial begin
        int gap;
        pop = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_ch <= c;
        do @(posedge i_clk); while (full);
        char_count++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    string pieces[] = '{
        "int", "void", "return", "if", "else", "while", "for", "x", "_a1", "counter9",
        "retur", "returns", "whilex", "Int", "0", "42", "9876", "(", ")", "{", "}",
        "[", "]", ";", ",", "?", ":", "~", "-", "->", "-=", "--", "+", "+=", "++",
        "<", "<=", "<<", "<<=", ">", ">=", ">>", ">>=", "&", "&=", "&&", "|", "|=",
        "||", ".", "..", "...", "*", "*=", "/", "/=", "%", "%=", "^", "^=", "=",
        "==", "!", "!=", "@", "#", "$"
    };

    initial begin
        int k, len;
        push = 1'b0;
        i_ch = 8'd0;
        i_rst_n = 1'b0;
        no_idle = 1'b0;
        char_count = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: keywords, growing punctuators, broken ellipsis, odd bytes
        send_text("int void return if else while for _x9 123\n");
        send_text("->-=--+=++<<=<=<<>>=>=>>&=&&&|=|||");
        send_text("...+..x. *=/=%=^===!=!~()[]{};,?:@");
        send_char(8'h80);
        send_char(8'hFF);
        send_char(8'h7F);
        send_text("\t\r\v\f.. abcdefgh<");
        send_char(8'd0);
        send_char(8'd0);

        // random: mostly token-shaped text, some raw bytes, quiet stretches
        while (char_count < 290) begin
            if ($urandom_range(0, 7) == 0) no_idle = ~no_idle;
            len = $urandom_range(5, 20);
            for (int i = 0; i < len; i++) begin
                k = $urandom_range(0, 19);
                if (k < 12) send_text(pieces[$urandom_range(0, pieces.size() - 1)]);
                else if (k < 15) send_char(" ");
                else if (k < 17) send_char("\n");
                else if (k < 18) send_char(8'($urandom_range(0, 255)));
                else send_char(pieces[$urandom_range(0, pieces.size() - 1)][0]);
            end
            send_char(8'd0);
        end

        no_idle = 1'b0;
        push <= 1'b0;
        @(posedge i_clk);

        while (waiting != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("covered %0d characters and %0d tokens, with keywords, all punctuators,",
                 char_count, token_count);
        $display("broken ellipses, odd bytes and random stalls on both sides");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
